// File: rtl/hrl_pkg.sv
// ----------------------------------------------------------------------------
// hrl_pkg
// Shared types and constants of the hex record loader: character classes,
// result kinds, error codes, record types and queue sizing.
// ----------------------------------------------------------------------------
package hrl_pkg;

    localparam int CHAR_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int ERR_W      = 3;
    localparam int OUT_DATA_W = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXT_LIN = 8'h04;

    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SYNTAX   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SHORT    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LENGTH   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_CHECKSUM = 3'd4;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        TK_SPACE,
        TK_COLON,
        TK_HEX,
        TK_OTHER,
        TK_EOS
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [3:0] nib;
    } t_tok;

endpackage

// File: rtl/hrl_front.sv
// ----------------------------------------------------------------------------
// hrl_front
// Character classifier: sorts each incoming character into separator,
// colon, hex digit (with its value), other, or end of stream.
// ----------------------------------------------------------------------------
module hrl_front (
    input  logic [hrl_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_eos,
    output hrl_pkg::t_tok              o_tok
);
    import hrl_pkg::*;

    always_comb begin
        o_tok.nib = 4'd0;
        if (i_eos) begin
            o_tok.cls = TK_EOS;
        end else if (i_char == 8'h20 || (i_char >= 8'h09 && i_char <= 8'h0d)) begin
            o_tok.cls = TK_SPACE;
        end else if (i_char == CHAR_COLON) begin
            o_tok.cls = TK_COLON;
        end else if (i_char >= 8'h30 && i_char <= 8'h39) begin
            o_tok.cls = TK_HEX;
            o_tok.nib = i_char[3:0];
        end else if ((i_char >= 8'h41 && i_char <= 8'h46) ||
                     (i_char >= 8'h61 && i_char <= 8'h66)) begin
            // 'A'..'F' and 'a'..'f' both carry 1..6 in the low bits.
            o_tok.cls = TK_HEX;
            o_tok.nib = i_char[3:0] + 4'd9;
        end else begin
            o_tok.cls = TK_OTHER;
        end
    end

endmodule

// File: rtl/hrl_queue.sv
// ----------------------------------------------------------------------------
// hrl_queue
// Small first-in first-out queue of classified characters between the
// classifier and the record parser.
// ----------------------------------------------------------------------------
module hrl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hrl_pkg::t_tok i_tok,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output hrl_pkg::t_tok o_tok
);
    import hrl_pkg::*;

    t_tok              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_DEPTH[QPTR_W:0]);
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/hrl_back.sv
// ----------------------------------------------------------------------------
// hrl_back
// Record parser: assembles hex bytes, tracks record fields and checksum,
// emits provisional data bytes and record verdicts into an output register.
// ----------------------------------------------------------------------------
module hrl_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  hrl_pkg::t_tok              i_tok,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output hrl_pkg::t_kind             o_kind,
    output logic [hrl_pkg::ADDR_W-1:0] o_address,
    output logic [hrl_pkg::BYTE_W-1:0] o_data_byte,
    output logic                       o_load_done,
    output logic [hrl_pkg::ERR_W-1:0]  o_error_code
);
    import hrl_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RECORD,
        PH_DONE
    } t_phase;

    t_phase      r_phase,      n_phase;
    logic [8:0]  r_byte_count, n_byte_count;
    logic [3:0]  r_high_nib,   n_high_nib;
    logic        r_nib_pend,   n_nib_pend;
    logic [7:0]  r_sum,        n_sum;
    logic [7:0]  r_rec_len,    n_rec_len;
    logic [7:0]  r_rec_type,   n_rec_type;
    logic [15:0] r_rec_addr,   n_rec_addr;
    logic [15:0] r_upper,      n_upper;
    logic [15:0] r_cand_upper, n_cand_upper;
    logic        r_tok_bad,    n_tok_bad;

    logic              r_out_valid;
    t_kind             r_kind,   n_kind;
    logic [ADDR_W-1:0] r_addr,   n_addr;
    logic [BYTE_W-1:0] r_data,   n_data;
    logic              r_done,   n_done;
    logic [ERR_W-1:0]  r_err,    n_err;
    logic              emit;

    logic [ERR_W-1:0]  verdict_err;
    logic [7:0]        new_byte;
    logic [8:0]        offset;
    logic [ADDR_W-1:0] byte_addr;

    assign o_pop = i_valid && (!r_out_valid || i_ready);

    assign new_byte  = {r_high_nib, i_tok.nib};
    assign offset    = r_byte_count - 9'd4;
    assign byte_addr = {r_upper, r_rec_addr} + {{(ADDR_W-9){1'b0}}, offset};

    always_comb begin
        if (r_tok_bad) begin
            verdict_err = ERR_SYNTAX;
        end else if (r_byte_count < 9'd5) begin
            verdict_err = ERR_SHORT;
        end else if (({2'b00, r_rec_len} + 10'd5) != {1'b0, r_byte_count}) begin
            verdict_err = ERR_LENGTH;
        end else if (r_sum != 8'd0) begin
            verdict_err = ERR_CHECKSUM;
        end else begin
            verdict_err = ERR_NONE;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_high_nib   = r_high_nib;
        n_nib_pend   = r_nib_pend;
        n_sum        = r_sum;
        n_rec_len    = r_rec_len;
        n_rec_type   = r_rec_type;
        n_rec_addr   = r_rec_addr;
        n_upper      = r_upper;
        n_cand_upper = r_cand_upper;
        n_tok_bad    = r_tok_bad;
        emit         = 1'b0;
        n_kind       = KIND_DATA;
        n_addr       = '0;
        n_data       = '0;
        n_done       = 1'b0;
        n_err        = ERR_NONE;

        if (o_pop) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_tok.cls == TK_EOS) begin
                        n_phase = PH_DONE;
                    end else if (i_tok.cls != TK_SPACE) begin
                        n_phase      = PH_RECORD;
                        n_byte_count = '0;
                        n_high_nib   = '0;
                        n_nib_pend   = 1'b0;
                        n_sum        = '0;
                        n_rec_len    = '0;
                        n_rec_type   = '0;
                        n_rec_addr   = '0;
                        n_cand_upper = '0;
                        n_tok_bad    = (i_tok.cls != TK_COLON);
                    end
                end
                PH_RECORD: begin
                    if (i_tok.cls == TK_EOS || i_tok.cls == TK_SPACE) begin
                        // The token has ended: give the record's verdict.
                        emit = 1'b1;
                        if (verdict_err != ERR_NONE) begin
                            n_phase = PH_DONE;
                            n_kind  = KIND_REJECT;
                            n_done  = 1'b1;
                            n_err   = verdict_err;
                        end else if (r_rec_type == REC_EOF) begin
                            n_phase = PH_DONE;
                            n_kind  = KIND_END;
                            n_done  = 1'b1;
                        end else begin
                            if (r_rec_type == REC_EXT_LIN) begin
                                n_upper = r_cand_upper;
                            end
                            n_kind  = KIND_ACCEPT;
                            n_done  = (i_tok.cls == TK_EOS);
                            n_phase = (i_tok.cls == TK_EOS) ? PH_DONE : PH_IDLE;
                        end
                    end else if (!r_tok_bad) begin
                        if (i_tok.cls != TK_HEX) begin
                            n_tok_bad = 1'b1;
                        end else if (!r_nib_pend) begin
                            n_high_nib = i_tok.nib;
                            n_nib_pend = 1'b1;
                        end else begin
                            n_nib_pend = 1'b0;
                            n_sum      = r_sum + new_byte;
                            if (r_byte_count == 9'd0) begin
                                n_rec_len = new_byte;
                            end else if (r_byte_count == 9'd1) begin
                                n_rec_addr[15:8] = new_byte;
                            end else if (r_byte_count == 9'd2) begin
                                n_rec_addr[7:0] = new_byte;
                            end else if (r_byte_count == 9'd3) begin
                                n_rec_type = new_byte;
                            end else begin
                                if (r_byte_count == 9'd4) begin
                                    n_cand_upper[15:8] = new_byte;
                                end else if (r_byte_count == 9'd5) begin
                                    n_cand_upper[7:0] = new_byte;
                                end
                                if (r_rec_type == REC_DATA && offset < {1'b0, r_rec_len}) begin
                                    emit   = 1'b1;
                                    n_kind = KIND_DATA;
                                    n_addr = byte_addr;
                                    n_data = new_byte;
                                end
                            end
                            if (r_byte_count != 9'h1ff) begin
                                n_byte_count = r_byte_count + 9'd1;
                            end
                        end
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= '0;
            r_high_nib   <= '0;
            r_nib_pend   <= 1'b0;
            r_sum        <= '0;
            r_rec_len    <= '0;
            r_rec_type   <= '0;
            r_rec_addr   <= '0;
            r_upper      <= '0;
            r_cand_upper <= '0;
            r_tok_bad    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_high_nib   <= n_high_nib;
            r_nib_pend   <= n_nib_pend;
            r_sum        <= n_sum;
            r_rec_len    <= n_rec_len;
            r_rec_type   <= n_rec_type;
            r_rec_addr   <= n_rec_addr;
            r_upper      <= n_upper;
            r_cand_upper <= n_cand_upper;
            r_tok_bad    <= n_tok_bad;
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop && emit) begin
            r_kind <= n_kind;
            r_addr <= n_addr;
            r_data <= n_data;
            r_done <= n_done;
            r_err  <= n_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_kind;
    assign o_address    = r_addr;
    assign o_data_byte  = r_data;
    assign o_load_done  = r_done;
    assign o_error_code = r_err;

endmodule

// File: rtl/hex_record_loader.sv
// ----------------------------------------------------------------------------
// hex_record_loader
// Intel HEX record parser fed one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one character of the hex file per transfer in
//   tdata; tlast high marks end of file, and its tdata is then ignored.
//   The master channel returns results: tuser is the kind (provisional
//   data byte, record accepted, record rejected, end record accepted),
//   tdata holds the byte address, the data byte and the error code, and
//   tlast is high on the result that finishes or aborts the load.
//   An accepted character is written to the queue; the parser then puts its
//   result, if any, in the master output register. One character is
//   taken every cycle; the rate is set by the parser stage, which handles
//   one queued character per cycle while its output register is free.
//   When the receiver stalls, the output register holds its result and a
//   four-entry character queue keeps absorbing input until it fills, then
//   slave tready drops. After reset the parser waits between records with
//   the upper address zero and the queue empty. Once the load is done,
//   further characters are taken and dropped without result.
// ----------------------------------------------------------------------------
module hex_record_loader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] address, [39:32] data_byte,
                                          // [42:40] error_code, rest zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast
);
    import hrl_pkg::*;

    t_tok              front_tok;
    t_tok              queue_tok;
    logic              queue_full;
    logic              queue_valid;
    logic              queue_pop;
    t_kind             out_kind;
    logic [ADDR_W-1:0] out_addr;
    logic [BYTE_W-1:0] out_data;
    logic [ERR_W-1:0]  out_err;

    hrl_front u_front (
        .i_char (i_s_axis_tdata),
        .i_eos  (i_s_axis_tlast),
        .o_tok  (front_tok)
    );

    hrl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_axis_tvalid),
        .i_tok   (front_tok),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_tok   (queue_tok)
    );

    hrl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_tok        (queue_tok),
        .o_pop        (queue_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_kind       (out_kind),
        .o_address    (out_addr),
        .o_data_byte  (out_data),
        .o_load_done  (o_m_axis_tlast),
        .o_error_code (out_err)
    );

    assign o_s_axis_tready = !queue_full;
    assign o_m_axis_tuser  = out_kind;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-ADDR_W-BYTE_W-ERR_W){1'b0}},
                              out_err, out_data, out_addr};

endmodule

// File: tb/sv/hrl_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrl_tb_pkg
// Result type, character helpers and the scoreboard of the hex record loader
// testbench. The scoreboard carries its own parser of the character stream.
// It turns every accepted character into the results that it should cause,
// and compares them in order with the results taken from the master side.
// ----------------------------------------------------------------------------
package hrl_tb_pkg;

    import hrl_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic        load_done;
        logic [2:0]  error_code;
    } t_hrl_result;

    typedef logic [7:0] t_byte_q[$];

    typedef enum logic [1:0] {
        PARSE_WAIT,
        PARSE_RECORD,
        PARSE_DONE
    } t_parse_state;

    typedef enum int {
        FLAW_NONE,
        FLAW_CHECKSUM,
        FLAW_LENGTH,
        FLAW_SHORT,
        FLAW_NO_COLON,
        FLAW_BAD_CHAR
    } t_rec_flaw;

    function automatic bit is_blank_char(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic int hex_digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    class hex_load_scoreboard;

        t_hrl_result  expected_results[$];
        int           errors;

        t_parse_state state;
        logic [8:0]   byte_cnt;
        logic [3:0]   hi_nib;
        bit           half_byte;
        logic [7:0]   byte_sum;
        logic [7:0]   rec_len;
        logic [7:0]   rec_type;
        logic [15:0]  rec_addr;
        logic [15:0]  upper_addr;
        logic [15:0]  cand_upper;
        bit           token_bad;

        function new();
            errors     = 0;
            state      = PARSE_WAIT;
            byte_cnt   = '0;
            hi_nib     = '0;
            half_byte  = 1'b0;
            byte_sum   = '0;
            rec_len    = '0;
            rec_type   = '0;
            rec_addr   = '0;
            upper_addr = '0;
            cand_upper = '0;
            token_bad  = 1'b0;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        function void push_result(logic [1:0] kind, logic [31:0] addr, logic [7:0] data,
                                  logic done, logic [2:0] err);
            t_hrl_result r;
            r.kind       = kind;
            r.address    = addr;
            r.data_byte  = data;
            r.load_done  = done;
            r.error_code = err;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void close_record(bit eos);
            logic [2:0] err;
            err = ERR_NONE;
            if (token_bad) err = ERR_SYNTAX;
            else if (byte_cnt < 9'd5) err = ERR_SHORT;
            else if ({1'b0, rec_len} + 9'd5 != byte_cnt) err = ERR_LENGTH;
            else if (byte_sum != 8'd0) err = ERR_CHECKSUM;

            if (err != ERR_NONE) begin
                state = PARSE_DONE;
                push_result(KIND_REJECT, '0, '0, 1'b1, err);
            end else if (rec_type == REC_EOF) begin
                state = PARSE_DONE;
                push_result(KIND_END, '0, '0, 1'b1, ERR_NONE);
            end else begin
                if (rec_type == REC_EXT_LIN) upper_addr = cand_upper;
                state = eos ? PARSE_DONE : PARSE_WAIT;
                push_result(KIND_ACCEPT, '0, '0, eos, ERR_NONE);
            end
        endfunction

        function void take_byte(logic [7:0] b);
            logic [31:0] offset;
            byte_sum = byte_sum + b;
            case (byte_cnt)
                9'd0: rec_len = b;
                9'd1: rec_addr[15:8] = b;
                9'd2: rec_addr[7:0] = b;
                9'd3: rec_type = b;
                default: begin
                    if (byte_cnt == 9'd4) cand_upper[15:8] = b;
                    else if (byte_cnt == 9'd5) cand_upper[7:0] = b;
                    offset = 32'(byte_cnt) - 32'd4;
                    // Only the first rec_len payload bytes of a data record go out.
                    if (rec_type == REC_DATA && offset < 32'(rec_len))
                        push_result(KIND_DATA, {upper_addr, rec_addr} + offset, b,
                                    1'b0, ERR_NONE);
                end
            endcase
            if (byte_cnt != 9'd511) byte_cnt = byte_cnt + 9'd1;
        endfunction

        // Called for every character transfer accepted on the slave side.
        function void note_char(logic [7:0] c, bit eos);
            int v;
            if (state == PARSE_DONE) return;
            if (eos) begin
                if (state == PARSE_RECORD) close_record(1'b1);
                else state = PARSE_DONE;
                return;
            end
            if (state == PARSE_WAIT) begin
                if (!is_blank_char(c)) begin
                    state      = PARSE_RECORD;
                    byte_cnt   = '0;
                    hi_nib     = '0;
                    half_byte  = 1'b0;
                    byte_sum   = '0;
                    rec_len    = '0;
                    rec_type   = '0;
                    rec_addr   = '0;
                    cand_upper = '0;
                    token_bad  = (c != CHAR_COLON);
                end
                return;
            end
            if (is_blank_char(c)) begin
                close_record(1'b0);
                return;
            end
            if (token_bad) return;
            v = hex_digit_value(c);
            if (v < 0) begin
                token_bad = 1'b1;
                return;
            end
            if (!half_byte) begin
                hi_nib    = 4'(v);
                half_byte = 1'b1;
                return;
            end
            half_byte = 1'b0;
            take_byte({hi_nib, 4'(v)});
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_hrl_result got);
            t_hrl_result want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d, address %08h, data %02h, error %0d",
                       got.kind, got.address, got.data_byte, got.error_code);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("address", want.address, got.address);
            compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            compare_field("load_done", 32'(want.load_done), 32'(got.load_done));
            compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
        endfunction

    endclass

endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the hex record loader. A single load is fed as a character
// stream: a directed set of records covering blanks, letter case, address
// carry and wrap, extended address lengths of zero, one, two and four, ignored types and odd digits,
// then random well-formed records, then one random way to finish or abort the
// load, then input that must be dropped. The sender works in bursts, the
// receiver stalls on its own pattern and once holds off long enough to back
// the block up. Every result is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    import hrl_pkg::*;
    import hrl_tb_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;    // [7:0] char_code
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;    // [31:0] address, [39:32] data_byte, [42:40] error_code
    logic [1:0]  o_m_axis_tuser;    // [1:0] kind
    logic        o_m_axis_tlast;

    hex_load_scoreboard sb;
    int burst_left;
    int chars_sent;
    int results_seen;

    hex_record_loader uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'd0, n};
        if ($urandom_range(0, 1) == 0) return 8'h41 + {4'd0, n} - 8'd10;
        return 8'h61 + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (hex_digit_value(c) >= 0 || is_blank_char(c));
        return c;
    endfunction

    function automatic logic [7:0] junk_start_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (is_blank_char(c) || c == CHAR_COLON);
        return c;
    endfunction

    // One character transfer, followed now and then by an idle gap.
    task automatic put_char(input logic [7:0] c, input bit eos);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_char(c, eos);
        chars_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 12);
        end
    endtask

    task automatic send_blanks(input int lo, input int hi);
        logic [7:0] blanks[6];
        blanks = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        repeat ($urandom_range(lo, hi)) put_char(blanks[$urandom_range(0, 5)], 1'b0);
    endtask

    task automatic send_record(input logic [7:0] rtype, input logic [15:0] addr,
                               input t_byte_q body, input t_rec_flaw flaw, input bit odd_digit);
        t_byte_q    bytes_q;
        logic [7:0] sum;
        int         cut;
        int         keep;
        bytes_q = {};
        bytes_q.insert(bytes_q.size(),
                       8'(body.size()) + ((flaw == FLAW_LENGTH) ? 8'd1 : 8'd0));
        bytes_q.insert(bytes_q.size(), addr[15:8]);
        bytes_q.insert(bytes_q.size(), addr[7:0]);
        bytes_q.insert(bytes_q.size(), rtype);
        foreach (body[i]) bytes_q.insert(bytes_q.size(), body[i]);
        sum = 8'd0;
        foreach (bytes_q[i]) sum = sum + bytes_q[i];
        bytes_q.insert(bytes_q.size(),
                       8'd0 - sum + ((flaw == FLAW_CHECKSUM) ? 8'd1 : 8'd0));
        if (flaw == FLAW_SHORT) begin
            keep = $urandom_range(0, 4);
            while (bytes_q.size() > keep) void'(bytes_q.pop_back());
        end
        cut = $urandom_range(0, 2 * bytes_q.size());

        if (flaw == FLAW_NO_COLON) put_char(junk_start_char(), 1'b0);
        else put_char(CHAR_COLON, 1'b0);
        foreach (bytes_q[i]) begin
            if (flaw == FLAW_BAD_CHAR && cut == 2 * i) put_char(non_hex_char(), 1'b0);
            put_char(hex_char(bytes_q[i][7:4]), 1'b0);
            if (flaw == FLAW_BAD_CHAR && cut == 2 * i + 1) put_char(non_hex_char(), 1'b0);
            put_char(hex_char(bytes_q[i][3:0]), 1'b0);
        end
        if (flaw == FLAW_BAD_CHAR && cut == 2 * bytes_q.size())
            put_char(non_hex_char(), 1'b0);
        if (odd_digit) put_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
    endtask

    function automatic t_byte_q random_body(int n);
        t_byte_q q;
        q = {};
        repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
        return q;
    endfunction

    initial begin : stimulus
        t_byte_q    body;
        logic [7:0] rtype;
        int         pick;
        int         n;
        int         big_at;
        int         rec_no;

        sb = new();
        burst_left = 0;
        chars_sent = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'd0;
        i_s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every blank character in front of the first record.
        put_char(8'd32, 1'b0);
        put_char(8'd9, 1'b0);
        put_char(8'd10, 1'b0);
        put_char(8'd11, 1'b0);
        put_char(8'd12, 1'b0);
        put_char(8'd13, 1'b0);
        body = '{8'h00, 8'hff};
        send_record(REC_DATA, 16'h0000, body, FLAW_NONE, 1'b0);
        send_blanks(1, 1);
        // The byte offset carries out of the 16-bit record address.
        body = '{8'h5a, 8'ha5, 8'h3c};
        send_record(REC_DATA, 16'hffff, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        body = '{8'hff, 8'hff};
        send_record(REC_EXT_LIN, 16'h0000, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        // With the upper address at its top the byte address wraps to zero.
        body = '{8'h11, 8'h22, 8'h33, 8'h44};
        send_record(REC_DATA, 16'hfffe, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        // Extended address of length one takes its low byte from the checksum.
        body = '{8'h12};
        send_record(REC_EXT_LIN, 16'h0000, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        body = '{8'h80};
        send_record(REC_DATA, 16'h1234, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        body = {};
        send_record(REC_EXT_LIN, 16'h0000, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        body = '{8'h00, 8'h08, 8'h99, 8'h77};
        send_record(REC_EXT_LIN, 16'h0000, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        body = {};
        send_record(REC_DATA, 16'h4000, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        body = '{8'h01, 8'h02};
        send_record(8'h02, 16'h0000, body, FLAW_NONE, 1'b0);
        send_blanks(1, 2);
        body = '{8'hc3};
        send_record(8'hff, 16'h5555, body, FLAW_NONE, 1'b1);
        send_blanks(1, 2);
        body = '{8'hab, 8'hcd};
        send_record(REC_DATA, 16'h0100, body, FLAW_NONE, 1'b1);
        send_blanks(1, 2);

        // Random well-formed records, with one record of the largest length.
        big_at = $urandom_range(3, 12);
        rec_no = 0;
        while (chars_sent < 520) begin
            pick = $urandom_range(0, 99);
            if (rec_no == big_at) begin
                rtype = REC_DATA;
                n = 255;
            end else if (pick < 65) begin
                rtype = REC_DATA;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(0, 8);
            end else if (pick < 85) begin
                rtype = REC_EXT_LIN;
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 2;
            end else begin
                rtype = 8'($urandom_range(2, 255));
                if (rtype == REC_EXT_LIN) rtype = 8'h05;
                n = $urandom_range(0, 6);
            end
            body = random_body(n);
            send_record(rtype, 16'($urandom_range(0, 65535)), body, FLAW_NONE,
                        $urandom_range(0, 9) == 0);
            send_blanks(1, ($urandom_range(0, 7) == 0) ? 8 : 2);
            rec_no++;
        end

        // The load ends one way per run.
        pick = $urandom_range(0, 7);
        body = random_body($urandom_range(0, 4));
        case (pick)
            0: begin
                body = {};
                send_record(REC_EOF, 16'h0000, body, FLAW_NONE, 1'b0);
                send_blanks(1, 2);
            end
            1: begin
                send_record(REC_DATA, 16'($urandom_range(0, 65535)), body, FLAW_NONE,
                            $urandom_range(0, 1) == 0);
                put_char(8'($urandom_range(0, 255)), 1'b1);
            end
            2: begin
                put_char(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                send_record(REC_DATA, 16'($urandom_range(0, 65535)), body,
                            t_rec_flaw'(pick - 2), 1'b0);
                send_blanks(1, 2);
            end
        endcase

        // Input after the end of the load is taken and dropped.
        put_char(8'h00, 1'b0);
        put_char(8'hff, 1'b1);
        repeat (30) put_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : receiver
        int          mode;
        int          mode_left;
        int          hold;
        t_hrl_result got;

        i_m_axis_tready <= 1'b0;
        mode = 0;
        mode_left = 0;
        hold = 0;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind       = o_m_axis_tuser;
                got.address    = o_m_axis_tdata[31:0];
                got.data_byte  = o_m_axis_tdata[39:32];
                got.error_code = o_m_axis_tdata[42:40];
                got.load_done  = o_m_axis_tlast;
                sb.check_result(got);
                results_seen++;
                // One long hold-off while characters keep coming fills the queue.
                if (results_seen == 30) hold = 300;
            end
            if (hold > 0) begin
                hold--;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= ~i_m_axis_tready;
                endcase
            end
        end
    end

endmodule
